/* rtl/mmcs_pkg.sv */
// Shared types and constants of the min/max contrast stretch unit.
`default_nettype none

package mmcs_pkg;

    localparam int SAMPLE_BITS      = 8;
    localparam int FIELD_LANES      = 3;
    localparam int PIXEL_FULL_SCALE = (1 << SAMPLE_BITS) - 1;
    localparam int NUM_BITS         = 2 * SAMPLE_BITS;
    localparam int DIV_STEPS        = SAMPLE_BITS;
    localparam int STEP_BITS        = $clog2(DIV_STEPS);
    localparam int OP_BITS          = 2;
    localparam int CHAN_BITS        = 2;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [OP_BITS-1:0] {
        OP_ACCUMULATE = 2'd0,
        OP_MAP        = 2'd1,
        OP_CLEAR      = 2'd2
    } op_t;

    // Per-cycle commands from the sequencer to every lane
    typedef struct packed {
        logic accumulate;
        logic clear;
        logic map_start;
        logic load;
        logic step;
    } lane_ctrl_t;

endpackage : mmcs_pkg

`default_nettype wire

/* rtl/mmcs_lane.sv */
// One channel lane: running min/max statistics and a bit-serial rounding divider.
`default_nettype none

module mmcs_lane (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire mmcs_pkg::lane_ctrl_t ctrl,
    input  wire                       lane_en,
    input  wire mmcs_pkg::sample_t    sample,
    output mmcs_pkg::sample_t         result
);
    import mmcs_pkg::*;

    sample_t min_reg, min_next;
    sample_t max_reg, max_next;
    sample_t off_reg, diff_reg;
    logic    zero_reg;
    sample_t rem_reg, low_reg, quo_reg;

    logic                  flat;
    sample_t               clamped;
    logic [NUM_BITS-1:0]   numer;
    logic [SAMPLE_BITS:0]  trial;
    logic                  fits;
    logic [SAMPLE_BITS:0]  trial_sub;

    // Statistics update
    always_comb begin
        min_next = min_reg;
        max_next = max_reg;
        if (ctrl.clear) begin
            min_next = sample_t'(PIXEL_FULL_SCALE);
            max_next = '0;
        end else if (ctrl.accumulate && lane_en) begin
            if (sample < min_reg) min_next = sample;
            if (sample > max_reg) max_next = sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= sample_t'(PIXEL_FULL_SCALE);
            max_reg <= '0;
        end else begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    // Clamp into [min, max] and take the offset
    assign flat = (max_reg <= min_reg);

    always_comb begin
        if (sample < min_reg) begin
            clamped = min_reg;
        end else if (sample > max_reg) begin
            clamped = max_reg;
        end else begin
            clamped = sample;
        end
    end

    // off * 255 as a shift and subtract, plus half the divisor for rounding
    assign numer = ({off_reg, {SAMPLE_BITS{1'b0}}} - NUM_BITS'(off_reg))
                 + NUM_BITS'(diff_reg >> 1);

    assign trial     = {rem_reg, low_reg[SAMPLE_BITS-1]};
    assign fits      = (trial >= {1'b0, diff_reg});
    assign trial_sub = trial - {1'b0, diff_reg};

    always_ff @(posedge aclk) begin
        if (ctrl.map_start) begin
            off_reg  <= clamped - min_reg;
            diff_reg <= max_reg - min_reg;
            zero_reg <= flat || !lane_en;
        end
        if (ctrl.load) begin
            rem_reg <= numer[NUM_BITS-1:SAMPLE_BITS];
            low_reg <= numer[SAMPLE_BITS-1:0];
            quo_reg <= '0;
        end else if (ctrl.step) begin
            rem_reg <= fits ? trial_sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
            low_reg <= {low_reg[SAMPLE_BITS-2:0], 1'b0};
            quo_reg <= {quo_reg[SAMPLE_BITS-2:0], fits};
        end
    end

    assign result = zero_reg ? sample_t'(0) : quo_reg;

endmodule : mmcs_lane

`default_nettype wire

/* rtl/mmcs_merge.sv */
// Output stage: gathers the lane quotients into one result item and holds it for the sink.
`default_nettype none

module mmcs_merge (
    input  wire                                      aclk,
    input  wire                                      aresetn,
    input  wire                                      load,
    input  wire mmcs_pkg::sample_t [mmcs_pkg::FIELD_LANES-1:0] lane_result,
    output logic                                     free,
    output logic                                     m_tvalid,
    input  wire                                      m_tready,
    output logic [mmcs_pkg::FIELD_LANES*mmcs_pkg::SAMPLE_BITS-1:0] m_tdata
);
    import mmcs_pkg::*;

    logic                                 valid_reg;
    logic [FIELD_LANES*SAMPLE_BITS-1:0]   data_reg;

    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= lane_result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule : mmcs_merge

`default_nettype wire

/* rtl/min_max_contrast_stretch_unit.sv */
// Top level of the min/max contrast stretch unit: sequencer, lanes and output stage.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+----------------------------------------
//  s_ input  | in        | s_tvalid/s_tready  | s_tuser: operation; s_tdata: samples
//  m_ result | out       | m_tvalid/m_tready  | m_tdata: stretched samples
//  cfg       | in        | cfg_wr_en          | cfg_wr_data: active_channels
//
//  Accumulate and clear items give no result.
//  A map item closes the input until its result is handed over: clamp, rounded numerator,
//  one quotient bit per cycle, hand-over; its result then waits in the output register.
//  Reset is synchronous, active low; statistics return to min 255 / max 0.
//  A finished result waits in the output register while new items are taken; the
//  sequencer holds in its last state only while that register is full and the sink not ready.
`default_nettype none

module min_max_contrast_stretch_unit #(
    parameter int LANES = 3
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // configuration
    input  wire                                 cfg_wr_en,
    input  wire  [mmcs_pkg::CHAN_BITS-1:0]      cfg_wr_data,   // active_channels
    // input items
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [23:0]                         s_tdata,       // sample_0, sample_1, sample_2
    input  wire  [mmcs_pkg::OP_BITS-1:0]        s_tuser,       // operation
    // result items
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [23:0]                         m_tdata        // stretched_0, _1, _2
);
    import mmcs_pkg::*;

    // Lanes actually built: limited by the three sample fields
    localparam int NLANES = (LANES < FIELD_LANES) ? LANES : FIELD_LANES;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic [CHAN_BITS-1:0]   chan_reg;
    logic [CHAN_BITS-1:0]   chan_count;
    logic                   accept;
    op_t                    op;
    lane_ctrl_t             ctrl;
    logic                   out_free;
    logic                   out_load;
    sample_t [FIELD_LANES-1:0] lane_result;

    // Configuration register: lane count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg <= CHAN_BITS'(1);
        end else if (cfg_wr_en) begin
            chan_reg <= cfg_wr_data;
        end
    end

    // A count of zero acts as one
    assign chan_count = (chan_reg == '0) ? CHAN_BITS'(1) : chan_reg;

    // Take one item at a time; a map item owns the lanes until its result is out
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser);

    // Decode the operation into lane commands; the fourth code is dropped
    always_comb begin
        ctrl = '0;
        if (accept) begin
            unique case (op)
                OP_ACCUMULATE: ctrl.accumulate = 1'b1;
                OP_MAP:        ctrl.map_start  = 1'b1;
                OP_CLEAR:      ctrl.clear      = 1'b1;
                default:       ctrl            = '0;
            endcase
        end
        ctrl.load = (state_reg == ST_PREP);
        ctrl.step = (state_reg == ST_DIV);
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (ctrl.map_start) state_next = ST_PREP;
            end
            ST_PREP: begin
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                step_next = step_reg + STEP_BITS'(1);
                if (step_reg == STEP_BITS'(DIV_STEPS - 1)) state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hold until the output register can take the result
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Lanes: one per sample field up to LANES, the rest give zero
    for (genvar g = 0; g < FIELD_LANES; g++) begin : g_lane
        if (g < NLANES) begin : g_used
            mmcs_lane u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (ctrl),
                .lane_en (CHAN_BITS'(g) < chan_count),
                .sample  (s_tdata[g*SAMPLE_BITS +: SAMPLE_BITS]),
                .result  (lane_result[g])
            );
        end else begin : g_unused
            assign lane_result[g] = '0;
        end
    end

    mmcs_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (out_load),
        .lane_result (lane_result),
        .free        (out_free),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule : min_max_contrast_stretch_unit

`default_nettype wire

/* rtl/mmcs_checker.sv */
// Port-level checks of the min/max contrast stretch unit, bound to the top level.
`default_nettype none

module mmcs_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire [1:0]  s_tuser,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [23:0] m_tdata
);
    import mmcs_pkg::*;

    // A waiting result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // Reset empties the output register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present after reset");

    // Input is not ready directly after a map item is taken
    a_map_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_MAP) |=> !s_tready)
        else $error("input taken directly after a map item");

    // No result appears in the cycle after any accepted item
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

endmodule : mmcs_checker

bind min_max_contrast_stretch_unit mmcs_checker u_mmcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/mmcs_stretch_checker.sv */
// Channel monitor for the contrast stretch unit: predicts stretched pixels and compares them.
`timescale 1ns / 100ps

module mmcs_stretch_checker
    import mmcs_pkg::*;
(
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     cfg_wr_en,
    input  wire  [CHAN_BITS-1:0]    cfg_wr_data,
    input  wire                     s_tvalid,
    input  wire                     s_tready,
    input  wire  [23:0]             s_tdata,     // sample_0, sample_1, sample_2
    input  wire  [OP_BITS-1:0]      s_tuser,     // operation
    input  wire                     m_tvalid,
    input  wire                     m_tready,
    input  wire  [23:0]             m_tdata,     // stretched_0, stretched_1, stretched_2
    output int                      mismatches,
    output int                      pending_results,
    output int                      results_checked
);

    sample_t                lane_lo [FIELD_LANES];
    sample_t                lane_hi [FIELD_LANES];
    logic [CHAN_BITS-1:0]   channel_reg;
    logic [23:0]            expected_stretch [$];
    int                     error_total;
    int                     checked_total;

    initial begin
        error_total     = 0;
        checked_total   = 0;
        mismatches      = 0;
        pending_results = 0;
        results_checked = 0;
    end

    // Zero behaves as one lane; anything above the lane count saturates.
    function automatic int lanes_in_play(logic [CHAN_BITS-1:0] ch);
        int n;
        n = (ch == '0) ? 1 : int'(ch);
        if (n > FIELD_LANES) n = FIELD_LANES;
        return n;
    endfunction

    function automatic sample_t stretch_level(sample_t s, sample_t lo, sample_t hi);
        int level;
        int span;
        if (hi <= lo) return '0;
        level = int'(s);
        if (level < int'(lo)) level = int'(lo);
        if (level > int'(hi)) level = int'(hi);
        span = int'(hi) - int'(lo);
        return sample_t'(((level - int'(lo)) * PIXEL_FULL_SCALE + span / 2) / span);
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] stretch mismatch: %s", $time, msg);
        error_total++;
    endtask

    always @(posedge aclk) begin
        logic [23:0] want;
        logic [23:0] pixel;
        sample_t     got_lane;
        sample_t     want_lane;
        int          n;

        if (!aresetn) begin
            for (int i = 0; i < FIELD_LANES; i++) begin
                lane_lo[i] = sample_t'(PIXEL_FULL_SCALE);
                lane_hi[i] = '0;
            end
            channel_reg = CHAN_BITS'(1);
            expected_stretch.delete();
        end else begin
            if (cfg_wr_en)
                channel_reg = cfg_wr_data;

            // Results leaving now belong to older items, so check them first.
            if (m_tvalid && m_tready) begin
                checked_total++;
                if (expected_stretch.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing outstanding", m_tdata));
                end else begin
                    want = expected_stretch.pop_front();
                    for (int i = 0; i < FIELD_LANES; i++) begin
                        got_lane  = m_tdata[8*i +: 8];
                        want_lane = want[8*i +: 8];
                        if (got_lane !== want_lane)
                            report_mismatch($sformatf("stretched_%0d got %0d want %0d",
                                                      i, got_lane, want_lane));
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                n     = lanes_in_play(channel_reg);
                pixel = s_tdata;
                case (s_tuser)
                    OP_ACCUMULATE: begin
                        for (int i = 0; i < n; i++) begin
                            if (pixel[8*i +: 8] < lane_lo[i]) lane_lo[i] = pixel[8*i +: 8];
                            if (pixel[8*i +: 8] > lane_hi[i]) lane_hi[i] = pixel[8*i +: 8];
                        end
                    end
                    OP_MAP: begin
                        want = '0;
                        for (int i = 0; i < n; i++)
                            want[8*i +: 8] = stretch_level(pixel[8*i +: 8], lane_lo[i],
                                                           lane_hi[i]);
                        expected_stretch.push_back(want);
                    end
                    OP_CLEAR: begin
                        for (int i = 0; i < FIELD_LANES; i++) begin
                            lane_lo[i] = sample_t'(PIXEL_FULL_SCALE);
                            lane_hi[i] = '0;
                        end
                    end
                    default: ;
                endcase
            end
        end

        mismatches      <= error_total;
        pending_results <= expected_stretch.size();
        results_checked <= checked_total;
    end

endmodule

/* tb/testbench.sv */
// Top of the contrast stretch testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps

module testbench;
    import mmcs_pkg::*;

    // Operation code the block must ignore
    localparam logic [OP_BITS-1:0] OP_RESERVED = 2'd3;
    // Cycles a map item can still be in flight after the last result
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int TARGET_ITEMS  = 800;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_PATTERN,
        RX_CHOKE
    } rx_mode_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [CHAN_BITS-1:0]   cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    wire                    s_tready;
    logic [23:0]            s_tdata     = '0;    // sample_0, sample_1, sample_2
    logic [OP_BITS-1:0]     s_tuser     = '0;    // operation
    wire                    m_tvalid;
    logic                   m_tready    = 1'b0;
    wire  [23:0]            m_tdata;             // stretched_0, stretched_1, stretched_2

    int         mismatches;
    int         pending_results;
    int         results_checked;

    int         cycle_count    = 0;
    int         items_sent     = 0;
    int         channel_writes = 0;
    int         burst_left     = 0;
    logic       tx_bursty      = 1'b0;
    rx_mode_t   rx_mode        = RX_OPEN;
    logic [3:0] rx_phase       = '0;
    logic [15:0] rx_pattern    = '0;

    min_max_contrast_stretch_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    mmcs_stretch_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("min_max_contrast_stretch_unit verification failed");
            $finish;
        end
    end

    // Result side: open, a random 16-bit pattern, or choked down to ready only when the
    // low three phase bits are zero, so that results pile up in the output register.
    always @(posedge aclk) begin
        rx_phase <= rx_phase + 4'd1;
        if (rx_phase == 4'd0)
            rx_pattern <= 16'($urandom);
        case (rx_mode)
            RX_PATTERN: m_tready <= rx_pattern[rx_phase];
            RX_CHOKE:   m_tready <= (rx_phase[2:0] == 3'd0);
            default:    m_tready <= 1'b1;
        endcase
    end

    // Present one item and hold it until accepted. In bursty mode drop
    // tvalid for a random gap whenever a burst runs out.
    task automatic send_item(input logic [OP_BITS-1:0] op,
                             input sample_t a, input sample_t b, input sample_t c);
        int gap;
        gap = 0;
        if (tx_bursty) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {c, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op != OP_RESERVED) items_sent++;
    endtask

    // Stop sending and wait until every predicted result has been seen.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    // Rewrite the lane count only once the unit has gone quiet.
    task automatic set_channels(input logic [CHAN_BITS-1:0] value);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        channel_writes++;
    endtask

    // One pixel: mostly inside a window, now and then a hard extreme.
    function automatic logic [23:0] pick_pixel(int base, int spread);
        logic [23:0] px;
        int          v;
        for (int i = 0; i < FIELD_LANES; i++) begin
            case ($urandom_range(0, 15))
                0:       v = 0;
                1:       v = PIXEL_FULL_SCALE;
                default: v = base + $urandom_range(0, spread);
            endcase
            if (v > PIXEL_FULL_SCALE) v = PIXEL_FULL_SCALE;
            px[8*i +: 8] = sample_t'(v);
        end
        return px;
    endfunction

    // A frame as the unit sees it in use: clear, an accumulate pass, then a
    // map pass over the same pixels. Sprinkle in reserved items, stray maps
    // in the first pass and foreign pixels in the second.
    task automatic run_frame();
        logic [23:0] frame_px [$];
        logic [23:0] px;
        int          n;
        int          base;
        int          spread;
        n      = $urandom_range(1, 16);
        base   = $urandom_range(0, PIXEL_FULL_SCALE);
        spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                             : $urandom_range(0, PIXEL_FULL_SCALE);
        if ($urandom_range(0, 9) != 0)
            send_item(OP_CLEAR, sample_t'($urandom), sample_t'($urandom),
                      sample_t'($urandom));
        for (int i = 0; i < n; i++) begin
            px = pick_pixel(base, spread);
            frame_px.push_back(px);
            send_item(OP_ACCUMULATE, px[7:0], px[15:8], px[23:16]);
            if ($urandom_range(0, 19) == 0) begin
                px = 24'($urandom);
                send_item(OP_RESERVED, px[7:0], px[15:8], px[23:16]);
            end
            if ($urandom_range(0, 29) == 0) begin
                px = 24'($urandom);
                send_item(OP_MAP, px[7:0], px[15:8], px[23:16]);
            end
        end
        for (int i = 0; i < n; i++) begin
            px = ($urandom_range(0, 3) != 0) ? frame_px[i] : 24'($urandom);
            send_item(OP_MAP, px[7:0], px[15:8], px[23:16]);
        end
    endtask

    initial begin
        logic [CHAN_BITS-1:0] next_channels;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Gray mode out of reset: nothing accumulated yet, so every lane is flat.
        send_item(OP_MAP, 8'hff, 8'h80, 8'h00);
        send_item(OP_RESERVED, 8'h12, 8'h34, 8'h56);
        // A single level seen is still flat.
        send_item(OP_ACCUMULATE, 8'h40, 8'h10, 8'h20);
        send_item(OP_MAP, 8'h40, 8'h10, 8'h20);
        send_item(OP_ACCUMULATE, 8'hc0, 8'hff, 8'hff);
        // Below the minimum, above the maximum, and in between.
        send_item(OP_MAP, 8'h00, 8'h00, 8'h00);
        send_item(OP_MAP, 8'hff, 8'hff, 8'hff);
        send_item(OP_MAP, 8'h80, 8'h80, 8'h80);

        // Colour: full range on two lanes, lane 2 flat.
        set_channels(2'd3);
        send_item(OP_CLEAR, 8'h00, 8'h00, 8'h00);
        send_item(OP_ACCUMULATE, 8'h00, 8'hff, 8'h80);
        send_item(OP_ACCUMULATE, 8'hff, 8'h00, 8'h80);
        send_item(OP_MAP, 8'hff, 8'h00, 8'h80);
        send_item(OP_MAP, 8'h00, 8'hff, 8'h7f);
        send_item(OP_MAP, 8'h80, 8'h80, 8'h80);

        // Two lanes: lane 2 is unused and must read zero.
        set_channels(2'd2);
        send_item(OP_CLEAR, 8'hff, 8'hff, 8'hff);
        send_item(OP_ACCUMULATE, 8'h10, 8'h20, 8'h30);
        send_item(OP_ACCUMULATE, 8'h20, 8'hf0, 8'hff);
        send_item(OP_MAP, 8'h18, 8'h88, 8'hff);

        // Zero lanes behaves as gray.
        set_channels(2'd0);
        send_item(OP_ACCUMULATE, 8'h05, 8'h06, 8'h07);
        send_item(OP_MAP, 8'h20, 8'h06, 8'h07);
        send_item(OP_MAP, 8'h11, 8'haa, 8'h55);

        // Random frames; shift lane count, idling and stalls every few frames.
        while (items_sent < TARGET_ITEMS) begin
            next_channels = ($urandom_range(0, 3) == 0) ? CHAN_BITS'($urandom)
                                                        : CHAN_BITS'(3);
            set_channels(next_channels);
            tx_bursty = ($urandom_range(0, 2) != 0);
            rx_mode   = rx_mode_t'($urandom_range(0, 2));
            repeat ($urandom_range(2, 5)) run_frame();
            if ($urandom_range(0, 3) == 0)
                hold_until_drained();
        end

        // Final drain, then let the pipeline settle before the verdict.
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("summary: %0d items over %0d lane-count writes, %0d stretched results checked",
                 items_sent, channel_writes, results_checked);
        if (mismatches == 0) begin
            $display("min_max_contrast_stretch_unit verification clean");
        end else begin
            $display("min_max_contrast_stretch_unit verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/mmcs_pkg.sv
rtl/mmcs_lane.sv
rtl/mmcs_merge.sv
rtl/min_max_contrast_stretch_unit.sv
rtl/mmcs_checker.sv
tb/mmcs_stretch_checker.sv
tb/testbench.sv
